// ===== hw/rtl/dslf_pkg.sv =====
// Shared types, constants and fixed-point helpers for the damped spring link force block.
// No dependencies; every dslf_* module imports this package.
package dslf_pkg;

  // Fixed-point format and derived step counts
  localparam int FracBits  = 16;
  localparam int DivSteps  = FracBits + 1;
  localparam int NumW      = 32 + FracBits;
  localparam int SqrtSteps = 32;

  // Direction threshold: 0.0001 rounded to the nearest fraction step
  localparam logic [31:0] EpsQ = 32'(((1 << FracBits) + 5000) / 10000);

  // Register reset values
  localparam logic [16:0] TimeStepRst = 17'(((1 << FracBits) + 30) / 60);
  localparam logic [30:0] BreakLenRst = 31'(10 << FracBits);
  localparam logic [30:0] DampGainRst = 31'(10 << FracBits);
  localparam logic [30:0] XferRateRst = 31'(5 << FracBits);

  // Saturation bounds and truncation bias
  localparam logic signed [33:0] Max34 = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] Min34 = 34'sh3_8000_0000;
  localparam logic signed [63:0] Max64 = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Min64 = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] RndBias = (64'sd1 <<< FracBits) - 64'sd1;

  typedef enum logic [1:0] {
    CfgTimeStep   = 2'd0,
    CfgBreakLen   = 2'd1,
    CfgDampGain   = 2'd2,
    CfgXferRate   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [16:0] time_step;
    logic [30:0] break_length;
    logic [30:0] damping_gain;
    logic [30:0] transfer_rate;
  } cfg_t;

  // Per-link operands carried down the pipeline
  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] rvx;
    logic signed [31:0] rvy;
    logic signed [31:0] ea;
    logic signed [31:0] eb;
    logic signed [31:0] diff;
    logic [30:0]        stiff;
    logic [30:0]        rest;
  } link_t;

  // Divider side data
  typedef struct packed {
    link_t       link;
    logic [31:0] span;
    logic        broken;
    logic        dir_ok;
  } dir_meta_t;

  // Saturate a 34-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > Max34) r = 32'sh7FFF_FFFF;
    else if (v < Min34) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Scale a product down by the fraction, truncating toward zero, then saturate
  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    logic signed [63:0] s;
    logic signed [31:0] r;
    if (p < 0) s = (p + RndBias) >>> FracBits;
    else s = p >>> FracBits;
    if (s > Max64) r = 32'sh7FFF_FFFF;
    else if (s < Min64) r = 32'sh8000_0000;
    else r = s[31:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/dslf_front.sv =====
// Front end: position/velocity/energy differences, squared distance and energy exchange.
// Depends on dslf_pkg. Five register stages.
module dslf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [31:0]   pos_a_x_i,
  input  logic signed [31:0]   pos_a_y_i,
  input  logic signed [31:0]   pos_b_x_i,
  input  logic signed [31:0]   pos_b_y_i,
  input  logic signed [31:0]   vel_a_x_i,
  input  logic signed [31:0]   vel_a_y_i,
  input  logic signed [31:0]   vel_b_x_i,
  input  logic signed [31:0]   vel_b_y_i,
  input  logic signed [31:0]   energy_a_i,
  input  logic signed [31:0]   energy_b_i,
  input  logic [30:0]          spring_stiffness_i,
  input  logic [30:0]          rest_length_i,
  input  dslf_pkg::cfg_t       cfg_i,
  output logic                 vld_o,
  output dslf_pkg::link_t      link_o,
  output logic [63:0]          sq_o
);
  import dslf_pkg::*;

  logic [4:0]         vld_q;
  link_t              s1_link_q, s2_link_q, s3_link_q, s4_link_q, s5_link_q;
  link_t              s1_link_d, s5_link_d;
  logic signed [31:0] s1_ed_q, s1_ed_d;
  logic signed [63:0] s2_sx_q, s2_sy_q, s2_ep_q;
  logic signed [63:0] s2_sx_d, s2_sy_d, s2_ep_d;
  logic [63:0]        s3_sq_q, s4_sq_q, s5_sq_q, s3_sq_d;
  logic signed [31:0] s3_e1_q, s3_e1_d;
  logic signed [63:0] s4_ep_q, s4_ep_d;

  // Stage 1: saturated differences
  always_comb begin
    s1_link_d       = '0;
    s1_link_d.dx    = sat32(34'(pos_a_x_i) - 34'(pos_b_x_i));
    s1_link_d.dy    = sat32(34'(pos_a_y_i) - 34'(pos_b_y_i));
    s1_link_d.rvx   = sat32(34'(vel_a_x_i) - 34'(vel_b_x_i));
    s1_link_d.rvy   = sat32(34'(vel_a_y_i) - 34'(vel_b_y_i));
    s1_link_d.ea    = energy_a_i;
    s1_link_d.eb    = energy_b_i;
    s1_link_d.stiff = spring_stiffness_i;
    s1_link_d.rest  = rest_length_i;
    s1_ed_d         = sat32(34'(energy_a_i) - 34'(energy_b_i));
  end

  // Stage 2: squares and energy times rate
  always_comb begin
    s2_sx_d = s1_link_q.dx * s1_link_q.dx;
    s2_sy_d = s1_link_q.dy * s1_link_q.dy;
    s2_ep_d = s1_ed_q * $signed({1'b0, cfg_i.transfer_rate});
  end

  // Stage 3: sum of squares, scale the rate product
  always_comb begin
    s3_sq_d = 64'(s2_sx_q) + 64'(s2_sy_q);
    s3_e1_d = qsat(s2_ep_q);
  end

  // Stage 4: times the time step
  assign s4_ep_d = s3_e1_q * $signed({15'b0, cfg_i.time_step});

  // Stage 5: energy moved across the link
  always_comb begin
    s5_link_d      = s4_link_q;
    s5_link_d.diff = qsat(s4_ep_q);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_link_q <= s1_link_d;
      s1_ed_q   <= s1_ed_d;
      s2_link_q <= s1_link_q;
      s2_sx_q   <= s2_sx_d;
      s2_sy_q   <= s2_sy_d;
      s2_ep_q   <= s2_ep_d;
      s3_link_q <= s2_link_q;
      s3_sq_q   <= s3_sq_d;
      s3_e1_q   <= s3_e1_d;
      s4_link_q <= s3_link_q;
      s4_sq_q   <= s3_sq_q;
      s4_ep_q   <= s4_ep_d;
      s5_link_q <= s5_link_d;
      s5_sq_q   <= s4_sq_q;
    end
  end

  assign vld_o  = vld_q[4];
  assign link_o = s5_link_q;
  assign sq_o   = s5_sq_q;

endmodule

// ===== hw/rtl/dslf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on dslf_pkg. SqrtSteps register stages.
module dslf_isqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  dslf_pkg::link_t link_i,
  input  logic [63:0]     sq_i,
  output logic            vld_o,
  output dslf_pkg::link_t link_o,
  output logic [31:0]     dist_o
);
  import dslf_pkg::*;

  logic [SqrtSteps-1:0] vld_q;
  logic [34:0] rem_q [SqrtSteps];
  logic [34:0] rem_d [SqrtSteps];
  logic [34:0] rem_in [SqrtSteps];
  logic [34:0] part [SqrtSteps];
  logic [34:0] trial [SqrtSteps];
  logic [31:0] root_q [SqrtSteps];
  logic [31:0] root_d [SqrtSteps];
  logic [31:0] root_in [SqrtSteps];
  logic [63:0] src_q [SqrtSteps];
  logic [63:0] src_d [SqrtSteps];
  logic [63:0] src_in [SqrtSteps];
  link_t       link_q [SqrtSteps];
  link_t       link_in [SqrtSteps];

  // Feed each stage from the one before it
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    src_in[0]  = sq_i;
    link_in[0] = link_i;
    for (int k = 1; k < SqrtSteps; k++) begin
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      src_in[k]  = src_q[k-1];
      link_in[k] = link_q[k-1];
    end
  end

  // Bring down two bits, try the next root bit
  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      part[k]  = {rem_in[k][32:0], src_in[k][63:62]};
      trial[k] = {1'b0, root_in[k], 2'b01};
      if (part[k] >= trial[k]) begin
        rem_d[k]  = part[k] - trial[k];
        root_d[k] = {root_in[k][30:0], 1'b1};
      end else begin
        rem_d[k]  = part[k];
        root_d[k] = {root_in[k][30:0], 1'b0};
      end
      src_d[k] = {src_in[k][61:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SqrtSteps-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SqrtSteps; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        src_q[k]  <= src_d[k];
        link_q[k] <= link_in[k];
      end
    end
  end

  assign vld_o  = vld_q[SqrtSteps-1];
  assign link_o = link_q[SqrtSteps-1];
  assign dist_o = root_q[SqrtSteps-1];

endmodule

// ===== hw/rtl/dslf_div.sv =====
// Pipelined direction divider: |delta| << FracBits over distance, both axes, one bit per stage.
// Depends on dslf_pkg. DivSteps register stages.
module dslf_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  dslf_pkg::link_t      link_i,
  input  logic [31:0]          dist_i,
  input  logic [30:0]          break_length_i,
  output logic                 vld_o,
  output dslf_pkg::dir_meta_t  meta_o,
  output logic [dslf_pkg::DivSteps-1:0] qx_o,
  output logic [dslf_pkg::DivSteps-1:0] qy_o
);
  import dslf_pkg::*;

  logic [DivSteps-1:0] vld_q;
  logic [NumW-1:0]     rx_in [DivSteps];
  logic [NumW-1:0]     ry_in [DivSteps];
  logic [NumW-1:0]     rx_q [DivSteps];
  logic [NumW-1:0]     ry_q [DivSteps];
  logic [NumW-1:0]     rx_d [DivSteps];
  logic [NumW-1:0]     ry_d [DivSteps];
  logic [NumW-1:0]     den [DivSteps];
  logic [DivSteps-1:0] qx_in [DivSteps];
  logic [DivSteps-1:0] qy_in [DivSteps];
  logic [DivSteps-1:0] qx_q [DivSteps];
  logic [DivSteps-1:0] qy_q [DivSteps];
  logic [DivSteps-1:0] qx_d [DivSteps];
  logic [DivSteps-1:0] qy_d [DivSteps];
  dir_meta_t           meta_in [DivSteps];
  dir_meta_t           meta_q [DivSteps];
  dir_meta_t           head;
  logic [31:0]         ax, ay;

  // Classify the link and take magnitudes
  always_comb begin
    head.link   = link_i;
    head.span   = dist_i;
    head.broken = dist_i > {1'b0, break_length_i};
    head.dir_ok = dist_i > EpsQ;
    ax = link_i.dx[31] ? (~link_i.dx + 32'd1) : link_i.dx;
    ay = link_i.dy[31] ? (~link_i.dy + 32'd1) : link_i.dy;
  end

  always_comb begin
    rx_in[0]   = {ax, {FracBits{1'b0}}};
    ry_in[0]   = {ay, {FracBits{1'b0}}};
    qx_in[0]   = '0;
    qy_in[0]   = '0;
    meta_in[0] = head;
    for (int k = 1; k < DivSteps; k++) begin
      rx_in[k]   = rx_q[k-1];
      ry_in[k]   = ry_q[k-1];
      qx_in[k]   = qx_q[k-1];
      qy_in[k]   = qy_q[k-1];
      meta_in[k] = meta_q[k-1];
    end
  end

  // Restoring step: quotient bit DivSteps-1-k at stage k
  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      den[k]  = NumW'(meta_in[k].span) << (DivSteps - 1 - k);
      rx_d[k] = rx_in[k];
      ry_d[k] = ry_in[k];
      qx_d[k] = qx_in[k];
      qy_d[k] = qy_in[k];
      if (rx_in[k] >= den[k]) begin
        rx_d[k] = rx_in[k] - den[k];
        qx_d[k][DivSteps-1-k] = 1'b1;
      end
      if (ry_in[k] >= den[k]) begin
        ry_d[k] = ry_in[k] - den[k];
        qy_d[k][DivSteps-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivSteps-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivSteps; k++) begin
        rx_q[k]   <= rx_d[k];
        ry_q[k]   <= ry_d[k];
        qx_q[k]   <= qx_d[k];
        qy_q[k]   <= qy_d[k];
        meta_q[k] <= meta_in[k];
      end
    end
  end

  assign vld_o  = vld_q[DivSteps-1];
  assign meta_o = meta_q[DivSteps-1];
  assign qx_o   = qx_q[DivSteps-1];
  assign qy_o   = qy_q[DivSteps-1];

endmodule

// ===== hw/rtl/dslf_force.sv =====
// Back end: spring and damping terms, force along the direction, final result beat.
// Depends on dslf_pkg. Seven register stages, the last one is the output register.
module dslf_force (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  dslf_pkg::dir_meta_t  meta_i,
  input  logic [dslf_pkg::DivSteps-1:0] qx_i,
  input  logic [dslf_pkg::DivSteps-1:0] qy_i,
  input  logic [30:0]          damping_gain_i,
  output logic                 vld_o,
  output logic                 broken_o,
  output logic signed [31:0]   force_x_o,
  output logic signed [31:0]   force_y_o,
  output logic signed [31:0]   new_energy_a_o,
  output logic signed [31:0]   new_energy_b_o
);
  import dslf_pkg::*;

  typedef logic signed [DivSteps:0] dir_t;

  logic [6:0]         vld_q;
  link_t              l0_q, l1_q, l2_q, l3_q, l4_q, l5_q;
  logic               b0_q, b1_q, b2_q, b3_q, b4_q, b5_q;
  dir_t               ux0_q, uy0_q, ux1_q, uy1_q, ux2_q, uy2_q, ux3_q, uy3_q;
  dir_t               ux4_q, uy4_q;
  dir_t               ux_d, uy_d;
  logic signed [31:0] sd0_q, sd_d;
  logic signed [63:0] pvx1_q, pvy1_q, ps1_q;
  logic signed [31:0] dot2_q, spr2_q, spr3_q;
  logic signed [63:0] pd3_q;
  logic signed [31:0] neg4_q;
  logic signed [63:0] pfx5_q, pfy5_q;
  logic               brk_q;
  logic signed [31:0] fx_q, fy_q, ea_q, eb_q;

  // Stage 0: signed direction and stretch
  always_comb begin
    ux_d = '0;
    uy_d = '0;
    if (meta_i.dir_ok) begin
      ux_d = meta_i.link.dx[31] ? -$signed({1'b0, qx_i}) : $signed({1'b0, qx_i});
      uy_d = meta_i.link.dy[31] ? -$signed({1'b0, qy_i}) : $signed({1'b0, qy_i});
    end
    sd_d = sat32($signed({2'b00, meta_i.span}) - $signed({3'b000, meta_i.link.rest}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Stage 0
      l0_q  <= meta_i.link;
      b0_q  <= meta_i.broken;
      ux0_q <= ux_d;
      uy0_q <= uy_d;
      sd0_q <= sd_d;
      // Stage 1: velocity along direction, spring product
      l1_q   <= l0_q;
      b1_q   <= b0_q;
      ux1_q  <= ux0_q;
      uy1_q  <= uy0_q;
      pvx1_q <= l0_q.rvx * ux0_q;
      pvy1_q <= l0_q.rvy * uy0_q;
      ps1_q  <= $signed({1'b0, l0_q.stiff}) * sd0_q;
      // Stage 2: dot product and spring term
      l2_q   <= l1_q;
      b2_q   <= b1_q;
      ux2_q  <= ux1_q;
      uy2_q  <= uy1_q;
      dot2_q <= sat32(34'(qsat(pvx1_q)) + 34'(qsat(pvy1_q)));
      spr2_q <= qsat(ps1_q);
      // Stage 3: damping product
      l3_q   <= l2_q;
      b3_q   <= b2_q;
      ux3_q  <= ux2_q;
      uy3_q  <= uy2_q;
      spr3_q <= spr2_q;
      pd3_q  <= dot2_q * $signed({1'b0, damping_gain_i});
      // Stage 4: negated magnitude
      l4_q   <= l3_q;
      b4_q   <= b3_q;
      ux4_q  <= ux3_q;
      uy4_q  <= uy3_q;
      neg4_q <= sat32(-34'(sat32(34'(spr3_q) + 34'(qsat(pd3_q)))));
      // Stage 5: force products
      l5_q   <= l4_q;
      b5_q   <= b4_q;
      pfx5_q <= neg4_q * ux4_q;
      pfy5_q <= neg4_q * uy4_q;
      // Stage 6: result beat, a broken link passes energy through
      brk_q <= b5_q;
      fx_q  <= b5_q ? 32'sd0 : qsat(pfx5_q);
      fy_q  <= b5_q ? 32'sd0 : qsat(pfy5_q);
      ea_q  <= b5_q ? l5_q.ea : sat32(34'(l5_q.ea) - 34'(l5_q.diff));
      eb_q  <= b5_q ? l5_q.eb : sat32(34'(l5_q.eb) + 34'(l5_q.diff));
    end
  end

  assign vld_o          = vld_q[6];
  assign broken_o       = brk_q;
  assign force_x_o      = fx_q;
  assign force_y_o      = fy_q;
  assign new_energy_a_o = ea_q;
  assign new_energy_b_o = eb_q;

endmodule

// ===== hw/rtl/damped_spring_link_force.sv =====
// Top level of the damped spring link force block: config registers, stall control, units.
// Depends on dslf_pkg, dslf_front, dslf_isqrt, dslf_div and dslf_force.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o with one link per beat (positions, velocities,
//   energies, stiffness, rest length). Output channel: out_valid_o / out_stall_i with
//   broken, force on body A and both new energy levels.
//   An accepted input beat passes through 5 front stages, 32 square root stages (one root
//   bit each), 17 divider stages (one quotient bit each) and 7 force stages, the last of
//   which is the output register.
//   Throughput is one link per cycle while no result is stalled; the whole pipeline advances together.
//   When the receiver stalls a valid result, every stage holds and in_stall_o rises in the
//   same cycle; nothing is dropped or repeated.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 time step, 1 break length,
//   2 damping gain, 3 transfer rate); write only while the pipeline is empty.
//   Reset clears all valid bits and loads the default register values.
module damped_spring_link_force (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_a_x_i,
  input  logic signed [31:0] pos_a_y_i,
  input  logic signed [31:0] pos_b_x_i,
  input  logic signed [31:0] pos_b_y_i,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic signed [31:0] energy_a_i,
  input  logic signed [31:0] energy_b_i,
  input  logic [30:0]        spring_stiffness_i,
  input  logic [30:0]        rest_length_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               broken_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] new_energy_a_o,
  output logic signed [31:0] new_energy_b_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [30:0]        cfg_data_i
);
  import dslf_pkg::*;

  cfg_t                cfg_q;
  logic                en;
  logic                fr_vld, sq_vld, dv_vld;
  link_t               fr_link, sq_link;
  logic [63:0]         fr_sq;
  logic [31:0]         sq_dist;
  dir_meta_t           dv_meta;
  logic [DivSteps-1:0] dv_qx, dv_qy;

  // Advance everything unless a result beat is held
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step     <= TimeStepRst;
      cfg_q.break_length  <= BreakLenRst;
      cfg_q.damping_gain  <= DampGainRst;
      cfg_q.transfer_rate <= XferRateRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTimeStep: cfg_q.time_step     <= cfg_data_i[16:0];
        CfgBreakLen: cfg_q.break_length  <= cfg_data_i;
        CfgDampGain: cfg_q.damping_gain  <= cfg_data_i;
        CfgXferRate: cfg_q.transfer_rate <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dslf_front u_front (
    .clk_i, .rst_ni,
    .en_i               (en),
    .vld_i              (in_valid_i),
    .pos_a_x_i, .pos_a_y_i, .pos_b_x_i, .pos_b_y_i,
    .vel_a_x_i, .vel_a_y_i, .vel_b_x_i, .vel_b_y_i,
    .energy_a_i, .energy_b_i, .spring_stiffness_i, .rest_length_i,
    .cfg_i              (cfg_q),
    .vld_o              (fr_vld),
    .link_o             (fr_link),
    .sq_o               (fr_sq)
  );

  dslf_isqrt u_isqrt (
    .clk_i, .rst_ni,
    .en_i   (en),
    .vld_i  (fr_vld),
    .link_i (fr_link),
    .sq_i   (fr_sq),
    .vld_o  (sq_vld),
    .link_o (sq_link),
    .dist_o (sq_dist)
  );

  dslf_div u_div (
    .clk_i, .rst_ni,
    .en_i           (en),
    .vld_i          (sq_vld),
    .link_i         (sq_link),
    .dist_i         (sq_dist),
    .break_length_i (cfg_q.break_length),
    .vld_o          (dv_vld),
    .meta_o         (dv_meta),
    .qx_o           (dv_qx),
    .qy_o           (dv_qy)
  );

  dslf_force u_force (
    .clk_i, .rst_ni,
    .en_i           (en),
    .vld_i          (dv_vld),
    .meta_i         (dv_meta),
    .qx_i           (dv_qx),
    .qy_i           (dv_qy),
    .damping_gain_i (cfg_q.damping_gain),
    .vld_o          (out_valid_o),
    .broken_o,
    .force_x_o,
    .force_y_o,
    .new_energy_a_o,
    .new_energy_b_o
  );

`ifndef SYNTHESIS
  // A broken link carries no force
  a_broken_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && broken_o |-> force_x_o == 32'sd0 && force_y_o == 32'sd0)
    else $error("broken link with nonzero force");

  // An empty output register never holds back the input side
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no result pending");

  // A held result beat freezes the pipeline
  a_hold_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(new_energy_a_o))
    else $error("held result changed");
`endif

endmodule
